>>> rtl/aes_pkg.sv
package aes_pkg;

  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } aes_out_t;

  // Block state: 16 bytes, byte 0 in the top bits, column-major.
  typedef logic [127:0] aes_blk_t;

  // Data carried from one round cell to the next.
  typedef struct packed {
    logic     vld;
    aes_blk_t blk;
    aes_blk_t rkey;
  } aes_stage_t;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // Multiply by x modulo the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // Next round constant byte; the first one is 8'h01.
  function automatic logic [7:0] next_rcon(input logic [7:0] rc);
    return xtime(rc);
  endfunction

endpackage

>>> rtl/aes_round.sv
// One round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey with the
// round key it derives from the previous one. Rcon is fixed per cell.
module aes_round #(
  parameter logic [7:0] Rcon    = 8'h01,
  parameter bit         LastRnd = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  aes_pkg::aes_stage_t stg_i,
  output aes_pkg::aes_stage_t stg_o
);
  import aes_pkg::*;

  aes_stage_t stg_q, stg_d;
  logic [7:0] b   [16];
  logic [7:0] s   [16];
  logic [7:0] m   [16];
  logic [31:0] w  [4];
  logic [31:0] nw [4];
  logic [31:0] tw;
  aes_blk_t   mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = stg_i.blk[127-8*i -: 8];
    end
    // Row r of column c comes from column c+r.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4*c+r] = SBOX[b[4*((c+r)%4)+r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
      for (int r = 0; r < 4; r++) begin
        m[4*c+r] = LastRnd ? s[4*c+r]
                 : s[4*c+r] ^ all ^ xtime(s[4*c+r] ^ s[4*c+((r+1)%4)]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      w[i] = stg_i.rkey[127-32*i -: 32];
    end
    tw = {SBOX[w[3][23:16]] ^ Rcon, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
    nw[0] = w[0] ^ tw;
    nw[1] = w[1] ^ nw[0];
    nw[2] = w[2] ^ nw[1];
    nw[3] = w[3] ^ nw[2];
    for (int i = 0; i < 16; i++) begin
      mixed[127-8*i -: 8] = m[i];
    end
    stg_d.vld  = stg_i.vld;
    stg_d.rkey = {nw[0], nw[1], nw[2], nw[3]};
    stg_d.blk  = mixed ^ stg_d.rkey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;

endmodule

>>> rtl/aes128_encrypt_block.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_ready | aes_in_t  (plaintext)
// out     | output    | out_valid/out_ready | aes_out_t (ciphertext)
// cfg     | input     | cfg_we_i          | cfg_idx_i, cfg_data_i (key halves)
// One block enters per cycle while the pipe is not stalled; the path from input to output has
// one register for the initial key addition and one per round cell.
// The round keys travel with each block, so a key write only affects later blocks.
// The pipe advances as a whole and stalls only when the output is full and not taken.
// Reset clears the key and all valid bits.
module aes128_encrypt_block #(
  parameter int unsigned NumRounds = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]            cfg_data_i,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aes_pkg::aes_in_t       in_data_i,
  output logic                   out_valid,
  input  logic                   out_ready,
  output aes_pkg::aes_out_t      out_data_o
);
  import aes_pkg::*;

  function automatic logic [7:0] rcon_of(input int unsigned n);
    logic [7:0] rc;
    rc = 8'h01;
    for (int unsigned i = 1; i < n; i++) begin
      rc = next_rcon(rc);
    end
    return rc;
  endfunction

  logic [63:0] key_hi_q, key_lo_q;
  aes_stage_t  pipe [NumRounds+1];
  aes_stage_t  head_q;
  logic        adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
        CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipe shifts when the last stage is empty or its transfer completes.
  assign adv      = !pipe[NumRounds].vld || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (adv) begin
      head_q.vld  <= in_valid;
      head_q.rkey <= {key_hi_q, key_lo_q};
      head_q.blk  <= {in_data_i.plaintext_high, in_data_i.plaintext_low}
                   ^ {key_hi_q, key_lo_q};
    end
  end

  assign pipe[0] = head_q;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round #(
      .Rcon   (rcon_of(g)),
      .LastRnd(g == NumRounds)
    ) u_rnd (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .stg_i (pipe[g-1]),
      .stg_o (pipe[g])
    );
  end

  assign out_valid                  = pipe[NumRounds].vld;
  assign out_data_o.ciphertext_high = pipe[NumRounds].blk[127:64];
  assign out_data_o.ciphertext_low  = pipe[NumRounds].blk[63:0];

endmodule

>>> rtl/aes_checker.sv
module aes_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input aes_pkg::aes_out_t out_data_o
);
  import aes_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("output changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind aes128_encrypt_block aes_checker u_aes_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data_o(out_data_o)
);

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_pkg::*;

  localparam int unsigned PipeLatency = 11;
  localparam int unsigned StallLimit  = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_KEY_HIGH;
  logic [63:0]         cfg_data_i = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  aes_in_t             in_data_i = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  aes_out_t            out_data_o;

  aes128_encrypt_block dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Key currently loaded into the block, as the predictor sees it.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  aes_out_t    cipher_q[$];
  int unsigned mismatches = 0;
  int unsigned blocks_sent = 0;
  int unsigned blocks_seen = 0;
  int unsigned key_writes = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [7:0] gf_x2(input logic [7:0] v);
    logic [8:0] t;
    t = {v, 1'b0};
    if (t[8]) t = t ^ 9'h11b;
    return t[7:0];
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic aes_out_t encrypt_block(input logic [63:0] kh, input logic [63:0] kl,
                                             input aes_in_t pt);
    logic [31:0] ks[44];
    logic [7:0]  st[16];
    logic [7:0]  tmp[16];
    logic [31:0] t;
    logic [7:0]  rc, a0, a1, a2, a3, all;
    logic [127:0] flat;
    aes_out_t    res;
    ks[0] = kh[63:32]; ks[1] = kh[31:0]; ks[2] = kl[63:32]; ks[3] = kl[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = ks[i-1];
      if (i % 4 == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_x2(rc);
      end
      ks[i] = ks[i-4] ^ t;
    end
    flat = {pt.plaintext_high, pt.plaintext_low};
    for (int i = 0; i < 16; i++) st[i] = flat[127-8*i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[4*c+r] = SBOX[st[4*((c+r)%4)+r]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ gf_x2(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ gf_x2(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ gf_x2(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ gf_x2(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        st[4*c]   ^= ks[4*rnd+c][31:24];
        st[4*c+1] ^= ks[4*rnd+c][23:16];
        st[4*c+2] ^= ks[4*rnd+c][15:8];
        st[4*c+3] ^= ks[4*rnd+c][7:0];
      end
    end
    for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
    res.ciphertext_high = flat[127:64];
    res.ciphertext_low  = flat[63:0];
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    key_writes++;
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] kh, input logic [63:0] kl);
    write_key(CFG_KEY_HIGH, kh);
    write_key(CFG_KEY_LOW, kl);
  endtask

  // Block must be empty before the key is touched.
  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  // Valid stays high after a transfer when the next item follows without a gap.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit gaps);
    aes_in_t     pt;
    int unsigned g;
    pt.plaintext_high = hi;
    pt.plaintext_low  = lo;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data_i <= pt;
    do @(posedge clk_i); while (!in_ready);
    cipher_q.push_back(encrypt_block(key_hi_q, key_lo_q, pt));
    blocks_sent++;
  endtask

  task automatic test_fips_vector();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    drain();
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    logic [63:0] pat[4] = '{64'h0, '1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa};
    for (int k = 0; k < 4; k++) begin
      drain();
      load_key(pat[k], pat[3-k]);
      for (int p = 0; p < 4; p++) send_block(pat[p], pat[(p+k)%4], 1'b0);
    end
    drain();
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 30; phase++) begin
      drain();
      if ($urandom_range(0, 3) == 0) write_key(CFG_KEY_HIGH, rand64());
      else if ($urandom_range(0, 2) == 0) write_key(CFG_KEY_LOW, rand64());
      else load_key(rand64(), rand64());
      for (int n = 0; n < 50; n++) send_block(rand64(), rand64(), phase % 3 != 0);
      if (phase == 10) drain();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fips_vector();
    test_extremes();
    test_random_keys();
    drain();
    $display("Encrypted %0d blocks across %0d key register writes, with random stalls",
             blocks_seen, key_writes);
    $display("on both sides; directed cases included the standard vectors and all-0/1 keys.");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Sink side: random ready, with long stalls now and then.
  initial begin
    int unsigned g;
    @(posedge clk_i);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      aes_out_t exp_c;
      blocks_seen++;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ciphertext %h", out_data_o);
      end else begin
        exp_c = cipher_q.pop_front();
        if (exp_c.ciphertext_high !== out_data_o.ciphertext_high ||
            exp_c.ciphertext_low !== out_data_o.ciphertext_low) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ciphertext mismatch: expected %h_%h got %h_%h",
                     exp_c.ciphertext_high, exp_c.ciphertext_low,
                     out_data_o.ciphertext_high, out_data_o.ciphertext_low);
        end
      end
    end
  end

  // Stall watchdog: counts cycles with no transfer on the in or out channel and no key write.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_encrypt_block.sv
rtl/aes_checker.sv
dv/testbench.sv
